// ===== src/owus_pkg.sv =====
// ----------------------------------------------------------------------------
// owus_pkg: shared types and codes for the 1-Wire over UART sequencer
// Beat payload structs, command / action / mode codes and bus constants.
// ----------------------------------------------------------------------------
package owus_pkg;

  // request commands
  localparam logic [1:0] CMD_RESET = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;

  // response actions
  localparam logic [1:0] ACT_SEND      = 2'd0;
  localparam logic [1:0] ACT_RESET_END = 2'd1;
  localparam logic [1:0] ACT_WRITE_END = 2'd2;

  // sequencer modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  // UART bytes on the bus
  localparam logic [7:0] RESET_BYTE = 8'hF0;
  localparam logic [7:0] ONE_SLOT   = 8'hFF;
  localparam logic [7:0] ZERO_SLOT  = 8'h00;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // divisor reset values: 9600 and 115200 baud
  localparam logic [7:0] SLOW_DIV_RESET = 8'd217;
  localparam logic [7:0] FAST_DIV_RESET = 8'd253;

  // register map
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_SLOW_DIV = 1'b0;
  localparam logic        REG_FAST_DIV = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data;
  } owus_req_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
    logic [7:0] baud_divisor;
  } owus_rsp_t;

endpackage

// ===== src/onewire_uart_byte_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// onewire_uart_byte_sequencer_top: 1-Wire bus sequencing through a UART
//
// Usage:
//   req channel (req_valid/req_ready/req): commands from the host and bytes
//   received by the UART. A reset command asks for 0xF0 at the slow divisor;
//   a write command expands its byte LSB first into eight slot bytes
//   (0xFF = one, 0x00 = zero) at the fast divisor, one slot per echo beat.
//   rsp channel (rsp_valid/rsp_ready/rsp): either a byte for the UART to
//   send (with its divisor) or a finish beat carrying the reset echo or the
//   read-back byte. Echo beats while idle produce nothing.
//   APB port: slow divisor at 0x0, fast divisor at 0x4.
// Response: registered; rsp is valid in the cycle after the req beat is accepted (held in the output reg).
// Throughput: one req beat per cycle; the limit is the single output
//   register, so a beat is taken whenever it is empty or being drained.
// Reset: sync, active high; mode goes idle, divisors return to 217 / 253.
// Stall: while rsp is held by rsp_ready low, req_ready stays low; beats
//   that would produce no response still wait for the register to drain.
// ----------------------------------------------------------------------------
module onewire_uart_byte_sequencer_top
  import owus_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  owus_req_t         req,
  // response channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output owus_rsp_t         rsp,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [7:0] slow_divisor;
  logic [7:0] fast_divisor;

  // sequencer state
  logic [1:0] mode,       mode_next;
  logic [7:0] tx_bits,    tx_bits_next;
  logic [3:0] sent_count, sent_count_next;
  logic [3:0] rx_count,   rx_count_next;
  logic [7:0] rx_bits,    rx_bits_next;

  logic       emit;
  owus_rsp_t  res;
  logic       req_fire;
  logic       cfg_wr;

  // --------------------------------------------------------------------------
  // APB: always ready, write on the access phase
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {24'd0, (paddr[2] == REG_FAST_DIV) ? fast_divisor : slow_divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_divisor <= SLOW_DIV_RESET;
      fast_divisor <= FAST_DIV_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SLOW_DIV) slow_divisor <= pwdata[7:0];
      else                          fast_divisor <= pwdata[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // handshake: take a beat when the output register is free or draining
  // --------------------------------------------------------------------------
  assign req_ready = !rsp_valid || rsp_ready;
  assign req_fire  = req_valid && req_ready;

  // --------------------------------------------------------------------------
  // next state and response for the beat on req
  // --------------------------------------------------------------------------
  always_comb begin
    mode_next       = mode;
    tx_bits_next    = tx_bits;
    sent_count_next = sent_count;
    rx_count_next   = rx_count;
    rx_bits_next    = rx_bits;
    emit            = 1'b0;
    res             = '0;
    unique case (req.command)
      CMD_RESET: begin
        // aborts anything in flight
        mode_next        = MODE_RESET;
        emit             = 1'b1;
        res.action       = ACT_SEND;
        res.value        = RESET_BYTE;
        res.baud_divisor = slow_divisor;
      end
      CMD_WRITE: begin
        mode_next        = MODE_WRITE;
        tx_bits_next     = req.data;
        rx_bits_next     = 8'd0;
        rx_count_next    = 4'd0;
        sent_count_next  = 4'd1;
        emit             = 1'b1;
        res.action       = ACT_SEND;
        res.value        = req.data[0] ? ONE_SLOT : ZERO_SLOT;
        res.baud_divisor = fast_divisor;
      end
      CMD_RX: begin
        if (mode == MODE_RESET) begin
          mode_next  = MODE_IDLE;
          emit       = 1'b1;
          res.action = ACT_RESET_END;
          res.value  = req.data;
        end else if (mode == MODE_WRITE) begin
          // echo of 0xFF reads back as a one
          if (req.data == ONE_SLOT && rx_count < BITS_PER_BYTE)
            rx_bits_next = rx_bits | (8'd1 << rx_count[2:0]);
          rx_count_next = rx_count + 4'd1;
          emit          = 1'b1;
          if (sent_count >= BITS_PER_BYTE) begin
            mode_next  = MODE_IDLE;
            res.action = ACT_WRITE_END;
            res.value  = rx_bits_next;
          end else begin
            res.action       = ACT_SEND;
            res.value        = tx_bits[sent_count[2:0]] ? ONE_SLOT : ZERO_SLOT;
            res.baud_divisor = fast_divisor;
            sent_count_next  = sent_count + 4'd1;
          end
        end
      end
      default: ; // unused command code: no effect
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      tx_bits    <= 8'd0;
      sent_count <= 4'd0;
      rx_count   <= 4'd0;
      rx_bits    <= 8'd0;
    end else if (req_fire) begin
      mode       <= mode_next;
      tx_bits    <= tx_bits_next;
      sent_count <= sent_count_next;
      rx_count   <= rx_count_next;
      rx_bits    <= rx_bits_next;
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_fire && emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && emit) rsp <= res;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // during a write the slot count runs one ahead of the echo count
  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_WRITE |-> sent_count == rx_count + 4'd1)
    else $error("write slot and echo counts out of step");

  // a reset request always yields the reset pulse as a send beat
  a_reset_pulse: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.command == CMD_RESET |=>
      rsp_valid && rsp.action == ACT_SEND && rsp.value == RESET_BYTE)
    else $error("reset request did not produce reset pulse");

  // a write request restarts the read-back collection
  a_write_start: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.command == CMD_WRITE |=>
      mode == MODE_WRITE && rx_count == 4'd0 && sent_count == 4'd1)
    else $error("write request did not restart sequence");

  // finish beats carry no divisor
  a_finish_div: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action != ACT_SEND |-> rsp.baud_divisor == 8'd0)
    else $error("finish beat with nonzero divisor");

endmodule

// ===== test/owus_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// owus_tb_pkg: scoreboard for the 1-Wire over UART byte sequencer
// Tracks the sequencer state from accepted request beats and checks each
// response beat against the oldest predicted one.
// ----------------------------------------------------------------------------
package owus_tb_pkg;
  import owus_pkg::*;

  class onewire_slot_predictor;
    logic [7:0] slow_div;
    logic [7:0] fast_div;
    logic [1:0] mode;
    logic [7:0] tx_bits;
    logic [7:0] rx_bits;
    logic [3:0] sent_count;
    logic [3:0] rx_count;
    owus_rsp_t  due_beats[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned responses;
    int unsigned resets_done;
    int unsigned writes_done;

    function new();
      slow_div    = SLOW_DIV_RESET;
      fast_div    = FAST_DIV_RESET;
      mode        = MODE_IDLE;
      tx_bits     = '0;
      rx_bits     = '0;
      sent_count  = '0;
      rx_count    = '0;
      errors      = 0;
      requests    = 0;
      responses   = 0;
      resets_done = 0;
      writes_done = 0;
    endfunction

    function void set_divisor(logic idx, logic [7:0] val);
      if (idx == REG_SLOW_DIV) slow_div = val;
      else fast_div = val;
    endfunction

    function logic [7:0] divisor(logic idx);
      return (idx == REG_SLOW_DIV) ? slow_div : fast_div;
    endfunction

    function logic [7:0] slot(logic [2:0] pos);
      return tx_bits[pos] ? ONE_SLOT : ZERO_SLOT;
    endfunction

    function void push(logic [1:0] act, logic [7:0] val, logic [7:0] div);
      owus_rsp_t b;
      b.action       = act;
      b.value        = val;
      b.baud_divisor = div;
      due_beats.push_back(b);
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    function void note_request(owus_req_t r);
      requests++;
      case (r.command)
        CMD_RESET: begin
          mode = MODE_RESET;
          push(ACT_SEND, RESET_BYTE, slow_div);
        end
        CMD_WRITE: begin
          mode       = MODE_WRITE;
          tx_bits    = r.data;
          rx_bits    = '0;
          rx_count   = '0;
          sent_count = 4'd1;
          push(ACT_SEND, slot(3'd0), fast_div);
        end
        CMD_RX: begin
          if (mode == MODE_RESET) begin
            mode = MODE_IDLE;
            push(ACT_RESET_END, r.data, 8'd0);
          end else if (mode == MODE_WRITE) begin
            if (r.data == ONE_SLOT && rx_count < BITS_PER_BYTE)
              rx_bits[rx_count[2:0]] = 1'b1;
            rx_count = rx_count + 4'd1;
            if (sent_count >= BITS_PER_BYTE) begin
              mode = MODE_IDLE;
              push(ACT_WRITE_END, rx_bits, 8'd0);
            end else begin
              push(ACT_SEND, slot(sent_count[2:0]), fast_div);
              sent_count = sent_count + 4'd1;
            end
          end
        end
        default: ;  // unused command code: no effect
      endcase
    endfunction

    function void check_response(owus_rsp_t got);
      owus_rsp_t want;
      responses++;
      if (due_beats.size() == 0) begin
        $error("unexpected response beat: action %0d value 0x%02h div %0d",
               got.action, got.value, got.baud_divisor);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("value: expected 0x%02h, got 0x%02h", want.value, got.value);
        errors++;
      end
      if (got.baud_divisor !== want.baud_divisor) begin
        $error("baud_divisor: expected %0d, got %0d", want.baud_divisor, got.baud_divisor);
        errors++;
      end
      if (want.action == ACT_RESET_END) resets_done++;
      if (want.action == ACT_WRITE_END) writes_done++;
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for onewire_uart_byte_sequencer_top
// Directed reset / write / abort cases, then random well-formed 1-Wire
// sequences mixed with noise under several divisor settings. Sender bursts
// and receiver stalls vary; every response beat is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import owus_pkg::*;
  import owus_tb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;   // code the block must ignore
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned NUM_PHASES  = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  owus_req_t         req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  owus_rsp_t         rsp;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  onewire_slot_predictor sb;

  // sender pacing: burst length left, and whether this phase runs gap-free
  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned settings = 1;   // reset values count as the first setting

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  onewire_uart_byte_sequencer_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // hard stop in case a beat never shows up
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // response side: check every accepted beat; values sampled here are the
  // pre-edge ones since the block updates on nonblocking assignments
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // receiver stall pattern, independent of the sender: the style switches
  // every so often between always ready, coin flip, mostly stalled, and a
  // fixed periodic on / off rhythm
  int unsigned stall_kind = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_kind)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      2: rsp_ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ready <= ((stall_tick % 8) < 3);
    endcase
  end

  // One request beat. Between bursts valid may drop for a random gap; inside
  // a burst valid stays high and only the payload moves on.
  task automatic send_req(input logic [1:0] cmd, input logic [7:0] data);
    int unsigned gap;
    owus_req_t   r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        req       <= owus_req_t'(10'($urandom));   // junk while idle
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    r.command = cmd;
    r.data    = data;
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Drain: no beat on the way in, every predicted beat out, then a few more
  // cycles so a beat that produced nothing has surely left the block.
  task automatic settle();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom_range(0, 32'h00FF_FFFF)), val};   // upper bits are junk
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_divisor(idx, val);
  endtask

  task automatic apb_check(input logic idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== sb.divisor(idx)) begin
      $error("prdata: expected %0d, got %0d", sb.divisor(idx), prdata[7:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic. Mostly complete reset and write sequences with random
  // echo content; some are cut short so the next request aborts them, and
  // a share is noise (stray echoes, the unused command code).
  task automatic run_traffic(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    int unsigned echoes;
    logic [7:0]  echo;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_req(CMD_WRITE, 8'($urandom_range(0, 255)));
        echoes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
        repeat (echoes) begin
          if ($urandom_range(0, 4) == 0) echo = 8'($urandom_range(0, 255));
          else echo = $urandom_range(0, 1) ? ONE_SLOT : ZERO_SLOT;
          send_req(CMD_RX, echo);
        end
        done += 1 + echoes;
      end else if (pick < 80) begin
        send_req(CMD_RESET, 8'($urandom_range(0, 255)));
        done++;
        if ($urandom_range(0, 9) != 0) begin
          send_req(CMD_RX, 8'($urandom_range(0, 255)));
          done++;
        end
      end else if (pick < 92) begin
        // echo with nothing pending, or a stray one mid-sequence
        send_req(CMD_RX, $urandom_range(0, 1) ? ONE_SLOT : 8'($urandom_range(0, 255)));
      end else begin
        send_req(CMD_UNUSED, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [7:0] slow_v;
    logic [7:0] fast_v;
    sb = new();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // divisors must come out of reset at 9600 / 115200 baud values
    apb_check(REG_SLOW_DIV);
    apb_check(REG_FAST_DIV);

    // --- directed part, reset divisors ---
    // echo and unused command while idle: both ignored
    send_req(CMD_RX, 8'h5A);
    send_req(CMD_UNUSED, 8'hFF);
    // plain reset, echo of all zeros
    send_req(CMD_RESET, 8'h00);
    send_req(CMD_RX, 8'h00);
    // reset restarted by a second reset, then all-ones echo
    send_req(CMD_RESET, 8'hFF);
    send_req(CMD_RESET, 8'h00);
    send_req(CMD_RX, 8'hFF);
    // full write of 0xFF with near-miss echoes; unused command in the middle
    send_req(CMD_WRITE, 8'hFF);
    send_req(CMD_RX, 8'hFF);
    send_req(CMD_RX, 8'hFF);
    send_req(CMD_RX, 8'hFE);
    send_req(CMD_UNUSED, 8'h00);
    send_req(CMD_RX, 8'hFF);
    send_req(CMD_RX, 8'h00);
    send_req(CMD_RX, 8'hFF);
    send_req(CMD_RX, 8'h7F);
    send_req(CMD_RX, 8'hFF);
    // write aborted by another write, which in turn is aborted by a reset
    send_req(CMD_WRITE, 8'h5A);
    send_req(CMD_RX, 8'hFF);
    send_req(CMD_RX, 8'h00);
    send_req(CMD_WRITE, 8'h00);
    send_req(CMD_RESET, 8'h00);
    send_req(CMD_RX, 8'hE0);
    settle();

    // --- random phases, each under its own divisor setting ---
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin slow_v = 8'd0;   fast_v = 8'd255; end
        1: begin slow_v = 8'd255; fast_v = 8'd0;   end
        2: begin slow_v = 8'd0;   fast_v = 8'd0;   end
        3: begin slow_v = 8'd255; fast_v = 8'd255; end
        default: begin
          slow_v = 8'($urandom_range(0, 255));
          fast_v = 8'($urandom_range(0, 255));
        end
      endcase
      apb_write(REG_SLOW_DIV, slow_v);
      apb_write(REG_FAST_DIV, fast_v);
      apb_check(REG_SLOW_DIV);
      apb_check(REG_FAST_DIV);
      settings++;
      steady = (ph % 3 == 0);   // some phases send back to back
      run_traffic(PHASE_ITEMS);
      settle();
    end

    $display("run covered %0d request beats and %0d response beats over %0d divisor settings",
             sb.requests, sb.responses, settings);
    $display("  %0d resets and %0d byte writes finished, %0d mismatches",
             sb.resets_done, sb.writes_done, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/owus_pkg.sv
src/onewire_uart_byte_sequencer_top.sv
test/owus_tb_pkg.sv
test/tb_top.sv
